/* src/csq_pkg.sv */
package csq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 8;
  localparam int CNT_W       = 18;
  localparam int INIT_W      = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [OCC_W-1:0]        occ_t;
  typedef logic signed [CNT_W-1:0] cnt_t;
  typedef logic [ID_WIDTH-1:0]     id_t;
  typedef logic [INIT_W-1:0]       init_t;

  localparam cnt_t COUNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam occ_t OCC_FULL  = OCC_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_WAIT   = 2'd0,
    OP_SIGNAL = 2'd1,
    OP_CLOSE  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    K_PROCEED  = 3'd0,
    K_BLOCKED  = 3'd1,
    K_RELEASED = 3'd2,
    K_CLOSED   = 3'd3,
    K_FULL     = 3'd4
  } kind_t;

  typedef struct packed {
    logic we;
    ptr_t waddr;
    id_t  wdata;
    logic re;
    ptr_t raddr;
  } ram_req_t;

  typedef struct packed {
    cnt_t count;
    ptr_t head;
    ptr_t tail;
    occ_t occ;
  } csq_status_t;

  function automatic ptr_t next_ptr(ptr_t p);
    if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

endpackage

/* src/csq_if.sv */
interface csq_req_if;
  import csq_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  id_t        caller_id;
  modport source (output valid, operation, caller_id, input ready);
  modport sink   (input valid, operation, caller_id, output ready);
endinterface

interface csq_res_if;
  import csq_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  id_t        thread_id;
  logic       last;
  modport source (output valid, kind, thread_id, last, input ready);
  modport sink   (input valid, kind, thread_id, last, output ready);
endinterface

interface csq_cfg_if;
  import csq_pkg::*;
  logic  valid;
  logic  ready;
  init_t initial_count;
  modport source (output valid, initial_count, input ready);
  modport sink   (input valid, initial_count, output ready);
endinterface

/* src/counting_semaphore_wait_queue.sv */
// channel  dir  beat contents
// in_req   in   operation, caller_id
// out_res  out  kind, thread_id, last
// cfg_wr   in   initial_count
//
// wait: S_LAST; signal: S_POP when a waiter is released, then S_LAST
// close: S_DRAIN while waiters are queued, one waiter per cycle out of the queue ram unless
// out_res stalls, then S_LAST; each release loads its waiter from the registered queue ram read
// reset clears count, pointers and fill level; queue ram contents are left as they are
// a stalled out_res holds the machine in place; in_req is taken again once the last beat is loaded
module counting_semaphore_wait_queue (
  input logic       clk,
  input logic       rst_n,
  csq_req_if.sink   in_req,
  csq_res_if.source out_res,
  csq_cfg_if.sink   cfg_wr
);
  import csq_pkg::*;

  ram_req_t    ram_req;
  id_t         ram_rdata;
  csq_status_t st;

  csq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_req),
    .res       (out_res),
    .cfg       (cfg_wr),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .status    (st)
  );

  csq_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.occ <= OCC_FULL)
    else $error("queue fill level beyond depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    ((st.occ == '0) || (st.occ == OCC_FULL)) == (st.head == st.tail))
    else $error("queue pointers disagree with fill level");

  // count only goes negative by queuing, so it never drops below minus the depth
  a_neg_count: assert property (@(posedge clk) disable iff (!rst_n)
    st.count >= cnt_t'(-QUEUE_DEPTH))
    else $error("count below minus queue depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("queue push and pop in the same cycle");

endmodule

/* src/csq_ram.sv */
module csq_ram (
  input  logic              clk,
  input  csq_pkg::ram_req_t req,
  output csq_pkg::id_t      rdata
);
  import csq_pkg::*;

  id_t mem [QUEUE_DEPTH];
  id_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/csq_ctrl.sv */
module csq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  csq_req_if.sink              req,
  csq_res_if.source            res,
  csq_cfg_if.sink              cfg,
  output csq_pkg::ram_req_t    ram_req,
  input  csq_pkg::id_t         ram_rdata,
  output csq_pkg::csq_status_t status
);
  import csq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_POP, S_DRAIN, S_LAST} state_t;

  state_t state_r;
  cnt_t   count_r;
  ptr_t   head_r;
  ptr_t   tail_r;
  occ_t   occ_r;
  init_t  init_r;
  id_t    caller_r;
  kind_t  last_kind_r;
  logic   out_valid_r;
  kind_t  out_kind_r;
  id_t    out_id_r;
  logic   out_last_r;

  logic accept;
  logic out_free;
  logic do_push;
  logic do_pop;
  cnt_t cnt_inc;
  cnt_t cnt_init;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid_r || res.ready;
  assign cnt_inc  = (count_r < COUNT_MAX) ? count_r + cnt_t'(1) : count_r;
  assign cnt_init = signed'({{(CNT_W-INIT_W){1'b0}}, init_r});

  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    if (accept) begin
      unique case (req.operation)
        OP_WAIT:   do_push = (count_r < cnt_t'(1)) && (occ_r != OCC_FULL);
        OP_SIGNAL: do_pop  = (cnt_inc <= cnt_t'(0)) && (occ_r != '0);
        OP_CLOSE:  do_pop  = (occ_r != '0);
        default:   do_pop  = 1'b0;
      endcase
    end else if (state_r == S_DRAIN && out_free && occ_r != '0) begin
      // fetch next waiter while the current one is loaded into the output
      do_pop = 1'b1;
    end
    ram_req.we    = do_push;
    ram_req.waddr = tail_r;
    ram_req.wdata = req.caller_id;
    ram_req.re    = do_pop;
    ram_req.raddr = head_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        init_r <= cfg.initial_count;
      end
      if (out_valid_r && res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_push) begin
        tail_r <= next_ptr(tail_r);
        occ_r  <= occ_r + occ_t'(1);
      end
      if (do_pop) begin
        head_r <= next_ptr(head_r);
        occ_r  <= occ_r - occ_t'(1);
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            caller_r    <= req.caller_id;
            last_kind_r <= K_PROCEED;
            unique case (req.operation)
              OP_WAIT: begin
                state_r <= S_LAST;
                if (count_r < cnt_t'(1)) begin
                  if (occ_r == OCC_FULL) begin
                    last_kind_r <= K_FULL;
                  end else begin
                    count_r     <= count_r - cnt_t'(1);
                    last_kind_r <= K_BLOCKED;
                  end
                end else begin
                  count_r <= count_r - cnt_t'(1);
                end
              end
              OP_SIGNAL: begin
                count_r <= cnt_inc;
                state_r <= do_pop ? S_POP : S_LAST;
              end
              OP_CLOSE: begin
                if (occ_r != '0) begin
                  state_r <= S_DRAIN;
                end else begin
                  head_r  <= '0;
                  tail_r  <= '0;
                  count_r <= cnt_init;
                  state_r <= S_LAST;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_POP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= K_RELEASED;
            out_id_r    <= ram_rdata;
            out_last_r  <= 1'b0;
            state_r     <= S_LAST;
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= K_CLOSED;
            out_id_r    <= ram_rdata;
            out_last_r  <= 1'b0;
            if (occ_r == '0) begin
              head_r  <= '0;
              tail_r  <= '0;
              count_r <= cnt_init;
              state_r <= S_LAST;
            end
          end
        end
        S_LAST: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= last_kind_r;
            out_id_r    <= caller_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign req.ready     = (state_r == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign res.valid     = out_valid_r;
  assign res.kind      = out_kind_r;
  assign res.thread_id = out_id_r;
  assign res.last      = out_last_r;

  assign status.count = count_r;
  assign status.head  = head_r;
  assign status.tail  = tail_r;
  assign status.occ   = occ_r;

endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int MAX_REPORTS   = 20;

  typedef struct {
    logic [1:0] op;
    id_t        id;
  } req_t;

  typedef struct {
    kind_t kind;
    id_t   tid;
    logic  last;
  } res_t;

  logic clk;
  logic rst_n;

  csq_req_if in_req();
  csq_res_if out_res();
  csq_cfg_if cfg_wr();

  counting_semaphore_wait_queue dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  // semaphore state as the testbench sees it
  int    sem_count;
  id_t   waiters_q[$];
  init_t reload_val;

  req_t pending_reqs[$];
  res_t expected_res[$];

  bit fast_mode;
  bit hold_armed;
  bit hold_done;
  int hold_left;
  int burst_left;
  int gap_left;
  int pat_age;
  logic [7:0] stall_pat;

  int err_cnt;
  int cycle_cnt;
  int n_req;
  int n_full;
  int n_sig_rel;
  int n_close_rel;
  int n_beats;
  int n_cfg;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void expect_beat(kind_t k, id_t t, logic l);
    expected_res.push_back('{k, t, l});
  endfunction

  function automatic void semaphore_step(logic [1:0] op, id_t caller);
    id_t rel;
    case (op)
      OP_WAIT: begin
        if (sem_count - 1 < 0) begin
          if (waiters_q.size() >= QUEUE_DEPTH) begin
            expect_beat(K_FULL, caller, 1'b1);
            n_full++;
          end else begin
            sem_count--;
            waiters_q.push_back(caller);
            expect_beat(K_BLOCKED, caller, 1'b1);
          end
        end else begin
          sem_count--;
          expect_beat(K_PROCEED, caller, 1'b1);
        end
      end
      OP_SIGNAL: begin
        if (sem_count < int'(COUNT_MAX)) begin
          sem_count++;
        end
        if (sem_count <= 0 && waiters_q.size() > 0) begin
          rel = waiters_q.pop_front();
          expect_beat(K_RELEASED, rel, 1'b0);
          n_sig_rel++;
        end
        expect_beat(K_PROCEED, caller, 1'b1);
      end
      OP_CLOSE: begin
        while (waiters_q.size() > 0) begin
          rel = waiters_q.pop_front();
          expect_beat(K_CLOSED, rel, 1'b0);
          n_close_rel++;
        end
        sem_count = int'(reload_val);
        expect_beat(K_PROCEED, caller, 1'b1);
      end
      default: begin
        // unused opcode, block ignores it
      end
    endcase
  endfunction

  // request driver: bursts with random gaps, no gaps in fast mode
  always @(posedge clk) begin
    req_t r;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        semaphore_step(in_req.operation, in_req.caller_id);
        n_req++;
      end
      if (!in_req.valid || in_req.ready) begin
        if (gap_left > 0 && !fast_mode) begin
          gap_left--;
          in_req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          in_req.valid     <= 1'b1;
          in_req.operation <= r.op;
          in_req.caller_id <= r.id;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern (none in fast mode) and one long hold-off
  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      hold_left = 0;
      pat_age   = 0;
      stall_pat = 8'hFF;
    end else begin
      if (out_res.valid && out_res.ready) begin
        n_beats++;
        if (expected_res.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("%0t: unexpected beat kind=%0d id=%0d last=%0b", $realtime,
                     out_res.kind, out_res.thread_id, out_res.last);
          end
        end else begin
          e = expected_res.pop_front();
          if (out_res.kind !== e.kind || out_res.thread_id !== e.tid ||
              out_res.last !== e.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("%0t: mismatch expected kind=%0d id=%0d last=%0b,",
                       $realtime, e.kind, e.tid, e.last,
                       " got kind=%0d id=%0d last=%0b",
                       out_res.kind, out_res.thread_id, out_res.last);
            end
          end
        end
      end
      if (hold_armed && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else if (fast_mode) begin
        out_res.ready <= 1'b1;
      end else begin
        if (pat_age == 0) begin
          pat_age   = 48;
          stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        end
        pat_age--;
        out_res.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt,
               expected_res.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic void add_req(logic [1:0] op, id_t id);
    pending_reqs.push_back('{op, id});
  endfunction

  function automatic req_t rand_req(bit wait_heavy);
    req_t r;
    int   p;
    p = $urandom_range(0, 99);
    if (wait_heavy) begin
      r.op = (p < 68) ? OP_WAIT : (p < 95) ? OP_SIGNAL : (p < 98) ? OP_CLOSE : OP_UNUSED;
    end else begin
      r.op = (p < 30) ? OP_WAIT : (p < 90) ? OP_SIGNAL : (p < 97) ? OP_CLOSE : OP_UNUSED;
    end
    r.id = id_t'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_req.valid || expected_res.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_initial_count(init_t v);
    @(posedge clk);
    cfg_wr.valid         <= 1'b1;
    cfg_wr.initial_count <= v;
    do @(posedge clk);
    while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    reload_val = v;
    n_cfg++;
  endtask

  initial begin
    init_t phase_init[4];
    req_t  r;
    int    items;
    int    seg_len;
    bit    heavy;

    rst_n                = 1'b0;
    in_req.valid         = 1'b0;
    in_req.operation     = OP_WAIT;
    in_req.caller_id     = '0;
    out_res.ready        = 1'b0;
    cfg_wr.valid         = 1'b0;
    cfg_wr.initial_count = '0;
    sem_count  = 0;
    reload_val = '0;
    fast_mode  = 1'b0;
    hold_armed = 1'b0;
    hold_done  = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: count starts at zero
    add_req(OP_SIGNAL, 8'h00);
    add_req(OP_WAIT,   8'hFF);
    add_req(OP_WAIT,   8'h01);
    add_req(OP_UNUSED, 8'h5A);
    add_req(OP_SIGNAL, 8'hA5);
    // sixteen blocked, then the queue is full
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
      add_req(OP_WAIT, id_t'(8'h70 + i * 8));
    end
    add_req(OP_SIGNAL, 8'h3C);
    // queue full again; the tail wrapped during the blocked waits above
    add_req(OP_WAIT,   8'hE7);
    add_req(OP_CLOSE,  8'hC3);
    wait_idle();

    // largest reload value, no idling on either side
    write_initial_count(16'hFFFF);
    fast_mode = 1'b1;
    add_req(OP_CLOSE, 8'h22);
    add_req(OP_WAIT,  8'h11);
    for (int i = 0; i < 8; i++) begin
      add_req(OP_SIGNAL, id_t'(i));
    end
    repeat (3) add_req(OP_WAIT, 8'h99);
    add_req(OP_CLOSE, 8'h44);
    wait_idle();
    fast_mode = 1'b0;

    // random phases at several reload values
    phase_init = '{16'd0, 16'd2, 16'd5, init_t'($urandom_range(0, 3))};
    foreach (phase_init[p]) begin
      write_initial_count(phase_init[p]);
      if (p == 0) begin
        hold_armed = 1'b1;
      end
      add_req(OP_CLOSE, id_t'($urandom_range(0, 255)));
      items = 0;
      while (items < ITEMS_PER_PHASE) begin
        seg_len = $urandom_range(4, 24);
        heavy   = $urandom_range(0, 1);
        repeat (seg_len) begin
          r = rand_req(heavy);
          pending_reqs.push_back(r);
          if (r.op != OP_UNUSED) begin
            items++;
          end
        end
      end
      wait_idle();
    end

    $display("%0d requests, %0d beats checked; %0d full rejects,", n_req, n_beats, n_full,
             " %0d signal releases, %0d close releases", n_sig_rel, n_close_rel);
    $display("%0d initial_count writes, a full-scale reload and a %0d cycle receiver hold-off",
             n_cfg, HOLD_CYCLES);
    if (err_cnt == 0 && expected_res.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* counting_semaphore_wait_queue.f */
src/csq_pkg.sv
src/csq_if.sv
src/csq_ram.sv
src/csq_ctrl.sv
src/counting_semaphore_wait_queue.sv
sim/tb_top.sv
